@@ sv/slbi_pkg.sv @@
// slbi_pkg: types, codes and the colour table of the status indicator
// used by the channel interfaces and by status_led_buzzer_indicator_unit
package slbi_pkg;

  typedef enum logic [2:0] {
    REQ_TICK      = 3'd0,
    REQ_READY     = 3'd1,
    REQ_RELAY     = 3'd2,
    REQ_COMMAND   = 3'd3,
    REQ_DEGRADED  = 3'd4,
    REQ_FAULT     = 3'd5,
    REQ_REBOOT    = 3'd6
  } req_t;

  typedef enum logic [2:0] {
    PAT_OFF       = 3'd0,
    PAT_BOOTING   = 3'd1,
    PAT_READY     = 3'd2,
    PAT_ACCEPTED  = 3'd3,
    PAT_RELAY     = 3'd4,
    PAT_ATTENTION = 3'd5,
    PAT_REBOOT    = 3'd6,
    PAT_FAULT     = 3'd7
  } pattern_t;

  typedef enum logic [1:0] {
    TONE_SILENT   = 2'd0,
    TONE_ACCEPTED = 2'd1,
    TONE_REJECTED = 2'd2,
    TONE_REBOOT   = 2'd3
  } tone_t;

  typedef enum logic [2:0] {
    CFG_HW_ENABLE     = 3'd0,
    CFG_BUZZER_ENABLE = 3'd1,
    CFG_ACCEPT_HOLD   = 3'd2,
    CFG_ATTN_HOLD     = 3'd3,
    CFG_BEEP_ON       = 3'd4,
    CFG_BEEP_OFF      = 3'd5
  } cfg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int HOLD_W     = 16;
  localparam int BEEP_W     = 10;
  localparam int MASK_W     = 8;

  localparam logic [HOLD_W-1:0] ACCEPT_HOLD_RST = 16'd150;
  localparam logic [HOLD_W-1:0] ATTN_HOLD_RST   = 16'd600;
  localparam logic [BEEP_W-1:0] BEEP_ON_RST     = 10'd60;
  localparam logic [BEEP_W-1:0] BEEP_OFF_RST    = 10'd60;

  typedef struct packed {
    logic [2:0]        req_type;
    logic              flag_value;
    logic [MASK_W-1:0] relay_mask;
    logic [MASK_W-1:0] pulsing_mask;
    logic              command_accepted;
  } in_item_t;

  typedef struct packed {
    logic [2:0] pattern_code;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       buzzer_on;
    logic [1:0] tone_code;
  } out_item_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // dim selects the second phase of blinking and pulsing patterns
  function automatic rgb_t colour_lookup(pattern_t pat, logic dim);
    rgb_t c;
    c = '{r: 8'd0, g: 8'd0, b: 8'd0};
    case (pat)
      PAT_OFF:       c = '{r: 8'd0,  g: 8'd0,  b: 8'd0};
      PAT_BOOTING:   c = '{r: 8'd12, g: 8'd12, b: 8'd12};
      PAT_READY:     c = '{r: 8'd0,  g: 8'd32, b: 8'd0};
      PAT_ACCEPTED:  c = '{r: 8'd0,  g: 8'd96, b: 8'd0};
      PAT_RELAY:     c = '{r: 8'd0,  g: 8'd32, b: 8'd64};
      PAT_ATTENTION: c = dim ? '{r: 8'd10, g: 8'd6, b: 8'd0}
                             : '{r: 8'd80, g: 8'd48, b: 8'd0};
      PAT_REBOOT:    c = dim ? '{r: 8'd0, g: 8'd0, b: 8'd60}
                             : '{r: 8'd40, g: 8'd0, b: 8'd80};
      PAT_FAULT:     c = dim ? '{r: 8'd0, g: 8'd0, b: 8'd0}
                             : '{r: 8'd96, g: 8'd0, b: 8'd0};
      default:       c = '{r: 8'd0,  g: 8'd0,  b: 8'd0};
    endcase
    return c;
  endfunction

endpackage

@@ sv/slbi_if.sv @@
// slbi_in_if and slbi_out_if: valid/ready channels of the status indicator
// payload types come from slbi_pkg
interface slbi_in_if
  import slbi_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface slbi_out_if
  import slbi_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/status_led_buzzer_indicator_unit.sv @@
// status_led_buzzer_indicator_unit: LED pattern, colour and beep sequencer
// depends on slbi_pkg and the channel interfaces in slbi_if.sv
//
// Use: feed one item per 1 ms tick (req_type tick) and one item per status
// event on in_ch. Every accepted item gives exactly one result item on
// out_ch: the pattern code, its RGB colour and the buzzer drive, evaluated
// on the state after the item has been applied.
// The result is registered and is valid in the cycle after the item is accepted.
// Throughput: one item per cycle unless out_ch stalls; the state update and
// the evaluation are one pass of logic into the state and result registers.
// The result register acts as the output stage: while it is empty or being
// taken, in_ch.ready is high, so a receiver that stalls holds the block
// after one result is waiting, and nothing is lost.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle;
// indexes 0..5 are hardware enable, buzzer enable, accepted hold time,
// attention hold time, beep on time and beep gap; other indexes are ignored.
// Reset (rst_n low, synchronous) clears all flags, timers and the phase,
// restores the register defaults and empties the result register.
module status_led_buzzer_indicator_unit
  import slbi_pkg::*;
#(
  parameter int BLINK_HALF_MS = 250,
  parameter int PULSE_HALF_MS = 500,
  parameter int RELAY_COUNT   = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  slbi_in_if.sink               in_ch,
  slbi_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PH_W = $clog2(2 * PULSE_HALF_MS);
  localparam int BL_W = $clog2(BLINK_HALF_MS + 1);
  localparam logic [PH_W-1:0] PHASE_LAST = PH_W'(2 * PULSE_HALF_MS - 1);
  localparam logic [PH_W-1:0] PULSE_EDGE = PH_W'(PULSE_HALF_MS);
  localparam logic [BL_W-1:0] BLINK_LAST = BL_W'(BLINK_HALF_MS - 1);

  // configuration
  logic              hw_enable_r, buzzer_enable_r;
  logic [HOLD_W-1:0] accept_hold_r, attn_hold_r;
  logic [BEEP_W-1:0] beep_on_r, beep_off_r;

  // state
  logic [PH_W-1:0]        phase_r, phase_nxt;
  logic [BL_W-1:0]        blink_cnt_r, blink_cnt_nxt;
  logic                   blink_odd_r, blink_odd_nxt;
  logic [HOLD_W-1:0]      accept_left_r, accept_left_nxt;
  logic [HOLD_W-1:0]      attn_left_r, attn_left_nxt;
  logic [BEEP_W-1:0]      beep_wait_r, beep_wait_nxt;
  logic [1:0]             beeps_left_r, beeps_left_nxt;
  logic                   beep_active_r, beep_active_nxt;
  tone_t                  tone_r, tone_nxt;
  logic                   ready_r, ready_nxt;
  logic                   degraded_r, degraded_nxt;
  logic                   fault_r, fault_nxt;
  logic                   reboot_r, reboot_nxt;
  logic [RELAY_COUNT-1:0] relay_bits_r, relay_bits_nxt;
  logic [RELAY_COUNT-1:0] pulse_bits_r, pulse_bits_nxt;

  // result stage
  logic      out_valid_r;
  out_item_t out_item_r, out_item_nxt;
  logic      in_fire;

  assign in_ch.ready    = !out_valid_r || out_ch.ready;
  assign in_fire        = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_item_r;

  always_comb begin
    logic [BL_W-1:0] blink_inc;
    logic            do_load;
    tone_t           load_kind;
    pattern_t        pat;
    tone_t           tone_rep;
    logic            dim;
    rgb_t            rgb;

    phase_nxt       = phase_r;
    blink_cnt_nxt   = blink_cnt_r;
    blink_odd_nxt   = blink_odd_r;
    accept_left_nxt = accept_left_r;
    attn_left_nxt   = attn_left_r;
    beep_wait_nxt   = beep_wait_r;
    beeps_left_nxt  = beeps_left_r;
    beep_active_nxt = beep_active_r;
    tone_nxt        = tone_r;
    ready_nxt       = ready_r;
    degraded_nxt    = degraded_r;
    fault_nxt       = fault_r;
    reboot_nxt      = reboot_r;
    relay_bits_nxt  = relay_bits_r;
    pulse_bits_nxt  = pulse_bits_r;
    do_load         = 1'b0;
    load_kind       = TONE_SILENT;
    blink_inc       = blink_cnt_r + BL_W'(1);

    // apply the item
    case (req_t'(in_ch.payload.req_type))
      REQ_TICK: begin
        if (phase_r == PHASE_LAST) begin
          phase_nxt     = '0;
          blink_cnt_nxt = '0;
          blink_odd_nxt = 1'b0;
        end else begin
          phase_nxt = phase_r + PH_W'(1);
          if (blink_cnt_r == BLINK_LAST) begin
            blink_cnt_nxt = '0;
            blink_odd_nxt = !blink_odd_r;
          end else begin
            blink_cnt_nxt = blink_inc;
          end
        end
        if (accept_left_r != '0) accept_left_nxt = accept_left_r - HOLD_W'(1);
        if (attn_left_r != '0) attn_left_nxt = attn_left_r - HOLD_W'(1);
        if (beep_wait_r != '0) beep_wait_nxt = beep_wait_r - BEEP_W'(1);
      end
      REQ_READY:    ready_nxt = in_ch.payload.flag_value;
      REQ_RELAY: begin
        relay_bits_nxt = in_ch.payload.relay_mask[RELAY_COUNT-1:0];
        pulse_bits_nxt = in_ch.payload.pulsing_mask[RELAY_COUNT-1:0];
      end
      REQ_COMMAND: begin
        do_load = 1'b1;
        if (in_ch.payload.command_accepted) begin
          accept_left_nxt = accept_hold_r;
          load_kind       = TONE_ACCEPTED;
        end else begin
          attn_left_nxt = attn_hold_r;
          load_kind     = TONE_REJECTED;
        end
      end
      REQ_DEGRADED: degraded_nxt = in_ch.payload.flag_value;
      REQ_FAULT:    fault_nxt = in_ch.payload.flag_value;
      REQ_REBOOT: begin
        reboot_nxt = in_ch.payload.flag_value;
        do_load    = in_ch.payload.flag_value;
        load_kind  = TONE_REBOOT;
      end
      default: ;
    endcase

    // a new beep request restarts the sequence while hardware and buzzer are enabled
    if (do_load && hw_enable_r && buzzer_enable_r) begin
      beeps_left_nxt  = 2'(load_kind);
      tone_nxt        = load_kind;
      beep_active_nxt = 1'b0;
      beep_wait_nxt   = '0;
    end

    // pattern priority: off while hardware is disabled, else fault first
    if (!hw_enable_r)                           pat = PAT_OFF;
    else if (fault_nxt)                         pat = PAT_FAULT;
    else if (reboot_nxt)                        pat = PAT_REBOOT;
    else if (degraded_nxt || attn_left_nxt != '0) pat = PAT_ATTENTION;
    else if (accept_left_nxt != '0)             pat = PAT_ACCEPTED;
    else if ((relay_bits_nxt | pulse_bits_nxt) != '0) pat = PAT_RELAY;
    else if (ready_nxt)                         pat = PAT_READY;
    else                                        pat = PAT_BOOTING;

    // beep sequencer step
    tone_rep = tone_nxt;
    if (!buzzer_enable_r) begin
      tone_rep = TONE_SILENT;
    end else if (beeps_left_nxt == 2'd0 && !beep_active_nxt) begin
      tone_nxt = TONE_SILENT;
      tone_rep = TONE_SILENT;
    end else if (beep_wait_nxt != '0) begin
      tone_rep = tone_nxt;
    end else if (beep_active_nxt) begin
      beep_active_nxt = 1'b0;
      beep_wait_nxt   = beep_off_r;
    end else begin
      beep_active_nxt = 1'b1;
      beeps_left_nxt  = beeps_left_nxt - 2'd1;
      beep_wait_nxt   = beep_on_r;
    end

    case (pat)
      PAT_FAULT:                 dim = blink_odd_nxt;
      PAT_ATTENTION, PAT_REBOOT: dim = !(phase_nxt < PULSE_EDGE);
      default:                   dim = 1'b0;
    endcase
    rgb = colour_lookup(pat, dim);

    out_item_nxt.pattern_code = 3'(pat);
    out_item_nxt.red          = rgb.r;
    out_item_nxt.green        = rgb.g;
    out_item_nxt.blue         = rgb.b;
    out_item_nxt.buzzer_on    = hw_enable_r && buzzer_enable_r && beep_active_nxt;
    out_item_nxt.tone_code    = hw_enable_r ? 2'(tone_rep) : 2'(TONE_SILENT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_enable_r     <= 1'b1;
      buzzer_enable_r <= 1'b1;
      accept_hold_r   <= ACCEPT_HOLD_RST;
      attn_hold_r     <= ATTN_HOLD_RST;
      beep_on_r       <= BEEP_ON_RST;
      beep_off_r      <= BEEP_OFF_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HW_ENABLE:     hw_enable_r     <= cfg_data[0];
        CFG_BUZZER_ENABLE: buzzer_enable_r <= cfg_data[0];
        CFG_ACCEPT_HOLD:   accept_hold_r   <= cfg_data[HOLD_W-1:0];
        CFG_ATTN_HOLD:     attn_hold_r     <= cfg_data[HOLD_W-1:0];
        CFG_BEEP_ON:       beep_on_r       <= cfg_data[BEEP_W-1:0];
        CFG_BEEP_OFF:      beep_off_r      <= cfg_data[BEEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= '0;
      blink_cnt_r   <= '0;
      blink_odd_r   <= 1'b0;
      accept_left_r <= '0;
      attn_left_r   <= '0;
      beep_wait_r   <= '0;
      beeps_left_r  <= '0;
      beep_active_r <= 1'b0;
      tone_r        <= TONE_SILENT;
      ready_r       <= 1'b0;
      degraded_r    <= 1'b0;
      fault_r       <= 1'b0;
      reboot_r      <= 1'b0;
      relay_bits_r  <= '0;
      pulse_bits_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r       <= phase_nxt;
        blink_cnt_r   <= blink_cnt_nxt;
        blink_odd_r   <= blink_odd_nxt;
        accept_left_r <= accept_left_nxt;
        attn_left_r   <= attn_left_nxt;
        beep_wait_r   <= beep_wait_nxt;
        beeps_left_r  <= beeps_left_nxt;
        beep_active_r <= beep_active_nxt;
        tone_r        <= tone_nxt;
        ready_r       <= ready_nxt;
        degraded_r    <= degraded_nxt;
        fault_r       <= fault_nxt;
        reboot_r      <= reboot_nxt;
        relay_bits_r  <= relay_bits_nxt;
        pulse_bits_r  <= pulse_bits_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) out_item_r <= out_item_nxt;
  end

`ifndef ASSERT_OFF
  // an empty result stage never holds back the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty result stage");

  // disabled hardware reports pattern off and a silent buzzer
  a_hw_off: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !hw_enable_r) |=>
      (out_ch.payload.pattern_code == 3'(PAT_OFF) && !out_ch.payload.buzzer_on))
    else $error("output active while hardware disabled");

  // a sounding buzzer always belongs to a named beep pattern
  a_tone_named: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.payload.buzzer_on) |->
      (out_ch.payload.tone_code != 2'(TONE_SILENT)))
    else $error("buzzer on with silent pattern");

  // phase and blink counters stay inside their periods
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r <= PHASE_LAST) && (blink_cnt_r <= BLINK_LAST))
    else $error("phase counter out of range");
`endif

endmodule

@@ bench/testbench.sv @@
// testbench: self-checking bench for status_led_buzzer_indicator_unit
// needs slbi_pkg and the channel interfaces in slbi_if.sv; predicts each result
// item from its own model of the flags, timers, colour phases and beep sequencer
module testbench
  import slbi_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLINK_HALF   = 250;
  localparam int PULSE_HALF   = 500;
  localparam int RELAY_N      = 8;
  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 150;
  localparam int SWEEP_TICKS  = 520;

  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam logic [7:0] RELAY_KEEP = 8'((1 << RELAY_N) - 1);

  localparam int F_READY    = 0;
  localparam int F_DEGRADED = 1;
  localparam int F_FAULT    = 2;
  localparam int F_REBOOT   = 3;

  // bright and dim colour of each pattern, {r, g, b}
  localparam rgb_t LED_COLOURS [8][2] = '{
    '{24'h000000, 24'h000000},
    '{24'h0C0C0C, 24'h0C0C0C},
    '{24'h002000, 24'h002000},
    '{24'h006000, 24'h006000},
    '{24'h002040, 24'h002040},
    '{24'h503000, 24'h0A0600},
    '{24'h280050, 24'h00003C},
    '{24'h600000, 24'h000000}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  slbi_in_if  in_ch ();
  slbi_out_if out_ch ();

  status_led_buzzer_indicator_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // configuration mirror
  logic              hw_en_c;
  logic              buzz_en_c;
  logic [HOLD_W-1:0] accept_hold_c;
  logic [HOLD_W-1:0] attn_hold_c;
  logic [BEEP_W-1:0] beep_on_c;
  logic [BEEP_W-1:0] beep_off_c;

  // indicator state mirror
  logic [9:0]        phase_cnt;
  logic [HOLD_W-1:0] accept_cnt;
  logic [HOLD_W-1:0] attn_cnt;
  logic [BEEP_W-1:0] beep_timer;
  logic [1:0]        beeps_todo;
  logic              beep_sounding;
  tone_t             tone_now;
  logic [3:0]        flags_now;
  logic [7:0]        relays_on;
  logic [7:0]        relays_pulsing;

  out_item_t expected_status[$];
  int        fails = 0;
  int        cycle_count = 0;
  bit        steady = 1'b0;

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_beeps(tone_t kind);
    if (hw_en_c && buzz_en_c) begin
      beeps_todo    = kind;
      tone_now      = kind;
      beep_sounding = 1'b0;
      beep_timer    = '0;
    end
  endfunction

  function automatic out_item_t predict_status(in_item_t it);
    out_item_t res;
    pattern_t  pat;
    tone_t     tone;
    logic      dim;
    logic      buzz;
    rgb_t      c;
    case (it.req_type)
      REQ_TICK: begin
        if (int'(phase_cnt) + 1 >= 2 * PULSE_HALF) phase_cnt = '0;
        else phase_cnt = phase_cnt + 10'd1;
        if (accept_cnt != 0) accept_cnt = accept_cnt - HOLD_W'(1);
        if (attn_cnt != 0) attn_cnt = attn_cnt - HOLD_W'(1);
        if (beep_timer != 0) beep_timer = beep_timer - BEEP_W'(1);
      end
      REQ_READY: flags_now[F_READY] = it.flag_value;
      REQ_RELAY: begin
        relays_on      = it.relay_mask & RELAY_KEEP;
        relays_pulsing = it.pulsing_mask & RELAY_KEEP;
      end
      REQ_COMMAND: begin
        if (it.command_accepted) begin
          accept_cnt = accept_hold_c;
          queue_beeps(TONE_ACCEPTED);
        end else begin
          attn_cnt = attn_hold_c;
          queue_beeps(TONE_REJECTED);
        end
      end
      REQ_DEGRADED: flags_now[F_DEGRADED] = it.flag_value;
      REQ_FAULT: flags_now[F_FAULT] = it.flag_value;
      REQ_REBOOT: begin
        flags_now[F_REBOOT] = it.flag_value;
        if (it.flag_value) queue_beeps(TONE_REBOOT);
      end
      default: ;
    endcase

    if (!hw_en_c) pat = PAT_OFF;
    else if (flags_now[F_FAULT]) pat = PAT_FAULT;
    else if (flags_now[F_REBOOT]) pat = PAT_REBOOT;
    else if (flags_now[F_DEGRADED] || attn_cnt != 0) pat = PAT_ATTENTION;
    else if (accept_cnt != 0) pat = PAT_ACCEPTED;
    else if ((relays_on | relays_pulsing) != 0) pat = PAT_RELAY;
    else if (flags_now[F_READY]) pat = PAT_READY;
    else pat = PAT_BOOTING;

    // sequencer holds still while the buzzer is disabled
    tone = TONE_SILENT;
    if (buzz_en_c) begin
      if (beeps_todo == 0 && !beep_sounding) tone_now = TONE_SILENT;
      else if (beep_timer != 0) ;
      else if (beep_sounding) begin
        beep_sounding = 1'b0;
        beep_timer    = beep_off_c;
      end else begin
        beep_sounding = 1'b1;
        beeps_todo    = beeps_todo - 2'd1;
        beep_timer    = beep_on_c;
      end
      tone = tone_now;
    end
    buzz = buzz_en_c && beep_sounding;
    if (!hw_en_c) begin
      tone = TONE_SILENT;
      buzz = 1'b0;
    end

    if (pat == PAT_FAULT) dim = ((int'(phase_cnt) / BLINK_HALF) % 2) != 0;
    else if (pat == PAT_ATTENTION || pat == PAT_REBOOT) dim = int'(phase_cnt) >= PULSE_HALF;
    else dim = 1'b0;
    c = LED_COLOURS[int'(pat)][dim];

    res.pattern_code = pat;
    res.red          = c.r;
    res.green        = c.g;
    res.blue         = c.b;
    res.buzzer_on    = buzz;
    res.tone_code    = tone;
    return res;
  endfunction

  function automatic in_item_t status_item(logic [2:0] req, logic flag, logic [7:0] relay,
                                           logic [7:0] pulse, logic accepted);
    in_item_t it;
    it.req_type         = req;
    it.flag_value       = flag;
    it.relay_mask       = relay;
    it.pulsing_mask     = pulse;
    it.command_accepted = accepted;
    return it;
  endfunction

  function automatic logic [7:0] random_mask();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic in_item_t random_status_item();
    int         r;
    logic [2:0] req;
    r = $urandom_range(0, 99);
    if (r < 55) req = REQ_TICK;
    else if (r < 62) req = REQ_READY;
    else if (r < 70) req = REQ_RELAY;
    else if (r < 80) req = REQ_COMMAND;
    else if (r < 87) req = REQ_DEGRADED;
    else if (r < 93) req = REQ_FAULT;
    else if (r < 98) req = REQ_REBOOT;
    else req = REQ_UNUSED;
    // clearing is a little more likely so the lower priorities get reached
    return status_item(req, $urandom_range(0, 99) < 45, random_mask(), random_mask(),
                       1'($urandom_range(0, 1)));
  endfunction

  task automatic send_status_item(in_item_t it);
    int gap;
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_status.push_back(predict_status(it));
    gap = steady ? 0 : idle_length();
    if (gap != 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_until_quiet();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      CFG_HW_ENABLE:     hw_en_c       = value[0];
      CFG_BUZZER_ENABLE: buzz_en_c     = value[0];
      CFG_ACCEPT_HOLD:   accept_hold_c = value[HOLD_W-1:0];
      CFG_ATTN_HOLD:     attn_hold_c   = value[HOLD_W-1:0];
      CFG_BEEP_ON:       beep_on_c     = value[BEEP_W-1:0];
      CFG_BEEP_OFF:      beep_off_c    = value[BEEP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // every pattern but off, from the lowest priority up, relay masks, and the unused request type
  task automatic test_event_priority();
    send_status_item(status_item(REQ_TICK, 1'b0, 8'h00, 8'h00, 1'b0));
    send_status_item(status_item(REQ_UNUSED, 1'b1, 8'hFF, 8'hFF, 1'b1));
    send_status_item(status_item(REQ_READY, 1'b1, 8'h00, 8'h00, 1'b0));
    send_status_item(status_item(REQ_RELAY, 1'b0, 8'hFF, 8'h00, 1'b0));
    send_status_item(status_item(REQ_RELAY, 1'b1, 8'h00, 8'hFF, 1'b1));
    send_status_item(status_item(REQ_RELAY, 1'b0, 8'h00, 8'h00, 1'b0));
    send_status_item(status_item(REQ_COMMAND, 1'b0, 8'h00, 8'h00, 1'b1));
    send_status_item(status_item(REQ_COMMAND, 1'b1, 8'hFF, 8'hFF, 1'b0));
    send_status_item(status_item(REQ_DEGRADED, 1'b1, 8'h00, 8'h00, 1'b0));
    send_status_item(status_item(REQ_DEGRADED, 1'b0, 8'hFF, 8'hFF, 1'b1));
    send_status_item(status_item(REQ_REBOOT, 1'b1, 8'h00, 8'h00, 1'b0));
    send_status_item(status_item(REQ_FAULT, 1'b1, 8'h00, 8'h00, 1'b0));
    send_status_item(status_item(REQ_FAULT, 1'b0, 8'h00, 8'h00, 1'b0));
    send_status_item(status_item(REQ_REBOOT, 1'b0, 8'h00, 8'h00, 1'b0));
    send_status_item(status_item(REQ_READY, 1'b0, 8'h00, 8'h00, 1'b0));
  endtask

  // hardware off, buzzer off and zero hold times
  task automatic test_disable_paths();
    wait_until_quiet();
    write_reg(CFG_HW_ENABLE, 16'd0);
    send_status_item(status_item(REQ_TICK, 1'b0, 8'h00, 8'h00, 1'b0));
    send_status_item(status_item(REQ_COMMAND, 1'b0, 8'h00, 8'h00, 1'b1));
    wait_until_quiet();
    write_reg(CFG_HW_ENABLE, 16'd1);
    write_reg(CFG_BUZZER_ENABLE, 16'd0);
    send_status_item(status_item(REQ_COMMAND, 1'b0, 8'h00, 8'h00, 1'b0));
    send_status_item(status_item(REQ_REBOOT, 1'b1, 8'h00, 8'h00, 1'b0));
    send_status_item(status_item(REQ_TICK, 1'b0, 8'h00, 8'h00, 1'b0));
    wait_until_quiet();
    write_reg(CFG_BUZZER_ENABLE, 16'd1);
    write_reg(CFG_ACCEPT_HOLD, 16'd0);
    write_reg(CFG_ATTN_HOLD, 16'd0);
    send_status_item(status_item(REQ_REBOOT, 1'b0, 8'h00, 8'h00, 1'b0));
    send_status_item(status_item(REQ_COMMAND, 1'b0, 8'h00, 8'h00, 1'b1));
    send_status_item(status_item(REQ_COMMAND, 1'b0, 8'h00, 8'h00, 1'b0));
    wait_until_quiet();
    write_reg(CFG_ACCEPT_HOLD, ACCEPT_HOLD_RST);
    write_reg(CFG_ATTN_HOLD, ATTN_HOLD_RST);
  endtask

  // ticks past the blink change and into the dim pulse half, events now and then
  task automatic test_phase_sweep();
    in_item_t it;
    for (int i = 0; i < SWEEP_TICKS; i++) begin
      if ($urandom_range(0, 39) == 0) it = random_status_item();
      else it = status_item(REQ_TICK, 1'($urandom_range(0, 1)), random_mask(), random_mask(),
                            1'($urandom_range(0, 1)));
      send_status_item(it);
    end
  endtask

  task automatic test_random_settings();
    logic              hw;
    logic              bz;
    logic [HOLD_W-1:0] acc;
    logic [HOLD_W-1:0] att;
    logic [BEEP_W-1:0] on_t;
    logic [BEEP_W-1:0] off_t;
    for (int k = 0; k < 6; k++) begin
      hw    = 1'b1;
      bz    = 1'b1;
      acc   = 16'($urandom_range(0, 40));
      att   = 16'($urandom_range(0, 40));
      on_t  = 10'($urandom_range(1, 8));
      off_t = 10'($urandom_range(1, 8));
      case (k)
        1: begin
          acc   = 16'hFFFF;
          att   = 16'd0;
          on_t  = 10'd1023;
          off_t = 10'd1;
        end
        2: begin
          acc   = 16'd0;
          att   = 16'hFFFF;
          on_t  = 10'd1;
          off_t = 10'd1023;
        end
        3: begin
          bz    = 1'b0;
          on_t  = 10'd0;
          off_t = 10'd0;
        end
        4: hw = 1'b0;
        default: ;
      endcase
      wait_until_quiet();
      write_reg(CFG_HW_ENABLE, 16'(hw));
      write_reg(CFG_BUZZER_ENABLE, 16'(bz));
      write_reg(CFG_ACCEPT_HOLD, acc);
      write_reg(CFG_ATTN_HOLD, att);
      write_reg(CFG_BEEP_ON, 16'(on_t));
      write_reg(CFG_BEEP_OFF, 16'(off_t));
      steady = (k == 1);
      for (int i = 0; i < RANDOM_ITEMS / 6; i++) send_status_item(random_status_item());
      steady = 1'b0;
    end
  endtask

  // result side: random stalls on ready
  initial begin
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(0, 15)) @(negedge clk);
      n = steady ? 0 : idle_length();
      if (n != 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_status.size() == 0) begin
        $error("result item with nothing expected: pattern %0d", out_ch.payload.pattern_code);
        fails++;
      end else begin
        want = expected_status.pop_front();
        check_field("pattern_code", 8'(want.pattern_code), 8'(out_ch.payload.pattern_code));
        check_field("red", want.red, out_ch.payload.red);
        check_field("green", want.green, out_ch.payload.green);
        check_field("blue", want.blue, out_ch.payload.blue);
        check_field("buzzer_on", 8'(want.buzzer_on), 8'(out_ch.payload.buzzer_on));
        check_field("tone_code", 8'(want.tone_code), 8'(out_ch.payload.tone_code));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;

    hw_en_c        = 1'b1;
    buzz_en_c      = 1'b1;
    accept_hold_c  = ACCEPT_HOLD_RST;
    attn_hold_c    = ATTN_HOLD_RST;
    beep_on_c      = BEEP_ON_RST;
    beep_off_c     = BEEP_OFF_RST;
    phase_cnt      = '0;
    accept_cnt     = '0;
    attn_cnt       = '0;
    beep_timer     = '0;
    beeps_todo     = '0;
    beep_sounding  = 1'b0;
    tone_now       = TONE_SILENT;
    flags_now      = '0;
    relays_on      = '0;
    relays_pulsing = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_event_priority();
    test_disable_paths();
    test_phase_sweep();
    test_random_settings();
    wait_until_quiet();

    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
